// ===== rtl/hrbp_pkg.sv =====
`default_nettype none

package hrbp_pkg;

    localparam int unsigned LENGTH_BITS_DEF = 32;
    localparam int unsigned OUT_LEN_BITS    = 32;

    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    localparam logic [3:0] POS_MAX = 4'd15;

    localparam logic [127:0] TXT_GET     = {"get", 104'h0};
    localparam logic [127:0] TXT_POST    = {"post", 96'h0};
    localparam logic [127:0] TXT_HEAD    = {"head", 96'h0};
    localparam logic [127:0] TXT_VERSION = {"http/1.1", 64'h0};
    localparam logic [127:0] TXT_CLEN    = {"content-length", 16'h0};
    localparam logic [127:0] TXT_CONN    = {"connection", 48'h0};
    localparam logic [127:0] TXT_ALIVE   = {"keep-alive", 48'h0};

    typedef enum logic [2:0] {
        WORD_GET,
        WORD_POST,
        WORD_HEAD,
        WORD_VERSION,
        WORD_CLEN,
        WORD_CONN,
        WORD_ALIVE
    } t_word;

    typedef enum logic [1:0] {
        PH_LINE,
        PH_HEADER,
        PH_BODY,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        LS_METHOD_START,
        LS_METHOD,
        LS_URI_START,
        LS_URI,
        LS_VERSION,
        LS_LF
    } t_line;

    typedef enum logic [2:0] {
        HS_KEY_START,
        HS_KEY,
        HS_SPACE,
        HS_VAL_START,
        HS_VAL,
        HS_LF,
        HS_END_LF
    } t_hdr;

    typedef enum logic [1:0] {
        FIN_RUN,
        FIN_DONE,
        FIN_ERR
    } t_finish;

    typedef enum logic [2:0] {
        ROLE_METHOD,
        ROLE_URI,
        ROLE_VERSION,
        ROLE_KEY,
        ROLE_VALUE,
        ROLE_BODY,
        ROLE_DELIM,
        ROLE_IGNORED
    } t_role;

    typedef enum logic [1:0] {
        METH_NONE,
        METH_GET,
        METH_POST,
        METH_HEAD
    } t_method;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LENGTH,
        KIND_CONN
    } t_kind;

    typedef struct packed {
        logic       start_req;
        logic [7:0] data_byte;
    } t_beat;

    typedef struct packed {
        t_finish                  status;
        t_role                    byte_role;
        t_method                  method_code;
        logic                     conn_persist;
        logic [OUT_LEN_BITS-1:0]  body_length;
        logic [7:0]               echo_byte;
    } t_result;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            r = c + CASE_DIFF;
        end
        return r;
    endfunction

    function automatic logic [3:0] word_len(input t_word w);
        logic [3:0] r;
        case (w)
            WORD_GET:     r = 4'd3;
            WORD_POST:    r = 4'd4;
            WORD_HEAD:    r = 4'd4;
            WORD_VERSION: r = 4'd8;
            WORD_CLEN:    r = 4'd14;
            WORD_CONN:    r = 4'd10;
            WORD_ALIVE:   r = 4'd10;
            default:      r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [127:0] word_text(input t_word w);
        logic [127:0] r;
        case (w)
            WORD_GET:     r = TXT_GET;
            WORD_POST:    r = TXT_POST;
            WORD_HEAD:    r = TXT_HEAD;
            WORD_VERSION: r = TXT_VERSION;
            WORD_CLEN:    r = TXT_CLEN;
            WORD_CONN:    r = TXT_CONN;
            WORD_ALIVE:   r = TXT_ALIVE;
            default:      r = '0;
        endcase
        return r;
    endfunction

    function automatic logic word_hit(input t_word w, input logic [3:0] pos,
                                      input logic [7:0] lc);
        logic [127:0] txt;
        logic [6:0]   base;
        txt  = word_text(w);
        base = 7'd127 - {pos, 3'b000};
        return (pos < word_len(w)) && (txt[base -: 8] == lc);
    endfunction

    function automatic logic word_end(input t_word w, input logic [3:0] pos);
        return word_len(w) == pos;
    endfunction

    function automatic logic [3:0] pos_inc(input logic [3:0] pos);
        return (pos == POS_MAX) ? pos : pos + 4'd1;
    endfunction

    function automatic logic [2:0] feed_methods(input logic [2:0] cand,
                                                input logic [3:0] pos,
                                                input logic [7:0] lc);
        return cand & {word_hit(WORD_HEAD, pos, lc), word_hit(WORD_POST, pos, lc),
                       word_hit(WORD_GET, pos, lc)};
    endfunction

    function automatic logic [2:0] feed_keys(input logic [2:0] cand,
                                             input logic [3:0] pos,
                                             input logic [7:0] lc);
        return {cand[2], cand[1:0] & {word_hit(WORD_CONN, pos, lc),
                                      word_hit(WORD_CLEN, pos, lc)}};
    endfunction

    function automatic logic [2:0] feed_single(input logic [2:0] cand, input t_word w,
                                               input logic [3:0] pos,
                                               input logic [7:0] lc);
        return {cand[2:1], cand[0] & word_hit(w, pos, lc)};
    endfunction

    function automatic t_method end_methods(input logic [2:0] cand,
                                            input logic [3:0] pos);
        t_method r;
        r = METH_NONE;
        if (cand[0] && word_end(WORD_GET, pos)) begin
            r = METH_GET;
        end else if (cand[1] && word_end(WORD_POST, pos)) begin
            r = METH_POST;
        end else if (cand[2] && word_end(WORD_HEAD, pos)) begin
            r = METH_HEAD;
        end
        return r;
    endfunction

    function automatic t_kind end_keys(input logic [2:0] cand, input logic [3:0] pos);
        t_kind r;
        r = KIND_NONE;
        if (cand[0] && word_end(WORD_CLEN, pos)) begin
            r = KIND_LENGTH;
        end else if (cand[1] && word_end(WORD_CONN, pos)) begin
            r = KIND_CONN;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hrbp_if.sv =====
`default_nettype none

interface hrbp_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] data_byte;

    modport source (output valid, output start_req, output data_byte, input ready);
    modport sink   (input valid, input start_req, input data_byte, output ready);
endinterface

interface hrbp_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic [2:0]                          byte_role;
    logic [1:0]                          method_code;
    logic                                conn_persist;
    logic [hrbp_pkg::OUT_LEN_BITS-1:0]   body_length;
    logic [7:0]                          echo_byte;

    modport source (output valid, output status, output byte_role, output method_code,
                    output conn_persist, output body_length, output echo_byte,
                    input ready);
    modport sink   (input valid, input status, input byte_role, input method_code,
                    input conn_persist, input body_length, input echo_byte,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/hrbp_in_stage.sv =====
`default_nettype none

module hrbp_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hrbp_in_if.sink          i_req,
    input  logic             i_advance,
    output logic             o_valid,
    output hrbp_pkg::t_beat  o_beat
);

    logic            r_valid;
    hrbp_pkg::t_beat r_beat;
    logic            w_take;

    assign i_req.ready = !r_valid || i_advance;
    assign w_take      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_beat.start_req <= i_req.start_req;
            r_beat.data_byte <= i_req.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

// ===== rtl/hrbp_parse.sv =====
`default_nettype none

module hrbp_parse #(
    parameter int unsigned LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  hrbp_pkg::t_beat    i_beat,
    output hrbp_pkg::t_result  o_result
);

    hrbp_pkg::t_phase  r_phase,  s_phase,  n_phase;
    hrbp_pkg::t_line   r_line,   s_line,   n_line;
    hrbp_pkg::t_hdr    r_hdr,    s_hdr,    n_hdr;
    hrbp_pkg::t_kind   r_kind,   s_kind,   n_kind;
    hrbp_pkg::t_method r_method, s_method, n_method;
    hrbp_pkg::t_finish r_finish, s_finish, n_finish;
    logic [3:0]             r_pos,    s_pos,    n_pos;
    logic [2:0]             r_cand,   s_cand,   n_cand;
    logic                   r_alive,  s_alive,  n_alive;
    logic [LENGTH_BITS-1:0] r_len,    s_len,    n_len;
    logic [LENGTH_BITS-1:0] r_rem,    s_rem,    n_rem;

    hrbp_pkg::t_role        w_role;
    logic [7:0]             w_byte;
    logic [7:0]             w_lc;
    logic [LENGTH_BITS-1:0] w_rem_dec;

    logic [2:0]             vf_cand_in, vf_cand;
    logic [3:0]             vf_pos_in,  vf_pos;
    logic [LENGTH_BITS-1:0] vf_len_in,  vf_len;
    logic [3:0]             vf_d;
    logic                   vf_digit;
    logic [LENGTH_BITS+3:0] vf_mul;

    assign w_byte = i_beat.data_byte;
    assign w_lc   = hrbp_pkg::to_lower(w_byte);

    always_comb begin
        if (i_beat.start_req) begin
            s_phase  = hrbp_pkg::PH_LINE;
            s_line   = hrbp_pkg::LS_METHOD_START;
            s_hdr    = hrbp_pkg::HS_KEY_START;
            s_kind   = hrbp_pkg::KIND_NONE;
            s_method = hrbp_pkg::METH_NONE;
            s_finish = hrbp_pkg::FIN_RUN;
            s_pos    = '0;
            s_cand   = 3'b111;
            s_alive  = 1'b0;
            s_len    = '0;
            s_rem    = '0;
        end else begin
            s_phase  = r_phase;
            s_line   = r_line;
            s_hdr    = r_hdr;
            s_kind   = r_kind;
            s_method = r_method;
            s_finish = r_finish;
            s_pos    = r_pos;
            s_cand   = r_cand;
            s_alive  = r_alive;
            s_len    = r_len;
            s_rem    = r_rem;
        end
    end

    // header value feed, shared by the first and later value bytes
    always_comb begin
        if (s_hdr == hrbp_pkg::HS_VAL_START) begin
            vf_cand_in = 3'b001;
            vf_pos_in  = '0;
            vf_len_in  = (s_kind == hrbp_pkg::KIND_LENGTH) ? '0 : s_len;
        end else begin
            vf_cand_in = s_cand;
            vf_pos_in  = s_pos;
            vf_len_in  = s_len;
        end
        vf_digit = (w_byte >= hrbp_pkg::CHAR_ZERO) && (w_byte <= hrbp_pkg::CHAR_NINE);
        vf_d     = 4'(w_byte - hrbp_pkg::CHAR_ZERO);
        vf_mul   = {1'b0, vf_len_in, 3'b000} + {3'b000, vf_len_in, 1'b0}
                 + {{LENGTH_BITS{1'b0}}, vf_d};
        vf_cand  = vf_cand_in;
        vf_pos   = vf_pos_in;
        vf_len   = vf_len_in;
        case (s_kind)
            hrbp_pkg::KIND_LENGTH: begin
                if (vf_cand_in[0]) begin
                    if (vf_digit) begin
                        vf_cand[1] = 1'b1;
                        vf_len = (vf_mul[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                               ? {LENGTH_BITS{1'b1}} : vf_mul[LENGTH_BITS-1:0];
                    end else begin
                        vf_cand[0] = 1'b0;
                    end
                end
            end
            hrbp_pkg::KIND_CONN: begin
                vf_cand = hrbp_pkg::feed_single(vf_cand_in, hrbp_pkg::WORD_ALIVE,
                                                vf_pos_in, w_lc);
                vf_pos  = hrbp_pkg::pos_inc(vf_pos_in);
            end
            default: begin
            end
        endcase
    end

    assign w_rem_dec = (s_rem != '0) ? s_rem - LENGTH_BITS'(1) : s_rem;

    always_comb begin
        n_phase  = s_phase;
        n_line   = s_line;
        n_hdr    = s_hdr;
        n_kind   = s_kind;
        n_method = s_method;
        n_finish = s_finish;
        n_pos    = s_pos;
        n_cand   = s_cand;
        n_alive  = s_alive;
        n_len    = s_len;
        n_rem    = s_rem;
        w_role   = hrbp_pkg::ROLE_IGNORED;
        if (s_finish == hrbp_pkg::FIN_RUN) begin
            unique case (s_phase)
                hrbp_pkg::PH_LINE: begin
                    unique case (s_line)
                        hrbp_pkg::LS_METHOD_START: begin
                            n_cand = hrbp_pkg::feed_methods(3'b111, 4'd0, w_lc);
                            n_pos  = hrbp_pkg::pos_inc(4'd0);
                            n_line = hrbp_pkg::LS_METHOD;
                            w_role = hrbp_pkg::ROLE_METHOD;
                        end
                        hrbp_pkg::LS_METHOD: begin
                            if (w_byte != hrbp_pkg::CHAR_SP) begin
                                n_cand = hrbp_pkg::feed_methods(s_cand, s_pos, w_lc);
                                n_pos  = hrbp_pkg::pos_inc(s_pos);
                                w_role = hrbp_pkg::ROLE_METHOD;
                            end else begin
                                n_method = hrbp_pkg::end_methods(s_cand, s_pos);
                                if (n_method == hrbp_pkg::METH_NONE) begin
                                    n_finish = hrbp_pkg::FIN_ERR;
                                end
                                n_line = hrbp_pkg::LS_URI_START;
                                w_role = hrbp_pkg::ROLE_DELIM;
                            end
                        end
                        hrbp_pkg::LS_URI_START: begin
                            n_line = hrbp_pkg::LS_URI;
                            w_role = hrbp_pkg::ROLE_URI;
                        end
                        hrbp_pkg::LS_URI: begin
                            if (w_byte != hrbp_pkg::CHAR_SP) begin
                                w_role = hrbp_pkg::ROLE_URI;
                            end else begin
                                n_pos  = '0;
                                n_cand = 3'b001;
                                n_line = hrbp_pkg::LS_VERSION;
                                w_role = hrbp_pkg::ROLE_DELIM;
                            end
                        end
                        hrbp_pkg::LS_VERSION: begin
                            if (w_byte != hrbp_pkg::CHAR_CR) begin
                                n_cand = hrbp_pkg::feed_single(s_cand, hrbp_pkg::WORD_VERSION,
                                                               s_pos, w_lc);
                                n_pos  = hrbp_pkg::pos_inc(s_pos);
                                w_role = hrbp_pkg::ROLE_VERSION;
                            end else begin
                                if (!(s_cand[0] &&
                                      hrbp_pkg::word_end(hrbp_pkg::WORD_VERSION, s_pos))) begin
                                    n_finish = hrbp_pkg::FIN_ERR;
                                end
                                n_line = hrbp_pkg::LS_LF;
                                w_role = hrbp_pkg::ROLE_DELIM;
                            end
                        end
                        hrbp_pkg::LS_LF: begin
                            if (w_byte == hrbp_pkg::CHAR_LF) begin
                                n_phase = hrbp_pkg::PH_HEADER;
                                n_hdr   = hrbp_pkg::HS_KEY_START;
                            end else begin
                                n_finish = hrbp_pkg::FIN_ERR;
                            end
                            w_role = hrbp_pkg::ROLE_DELIM;
                        end
                        default: begin
                        end
                    endcase
                end
                hrbp_pkg::PH_HEADER: begin
                    unique case (s_hdr)
                        hrbp_pkg::HS_KEY_START: begin
                            if (w_byte == hrbp_pkg::CHAR_CR) begin
                                n_hdr  = hrbp_pkg::HS_END_LF;
                                w_role = hrbp_pkg::ROLE_DELIM;
                            end else begin
                                n_cand = hrbp_pkg::feed_keys(3'b011, 4'd0, w_lc);
                                n_pos  = hrbp_pkg::pos_inc(4'd0);
                                n_hdr  = hrbp_pkg::HS_KEY;
                                w_role = hrbp_pkg::ROLE_KEY;
                            end
                        end
                        hrbp_pkg::HS_KEY: begin
                            if (w_byte != hrbp_pkg::CHAR_COLON) begin
                                n_cand = hrbp_pkg::feed_keys(s_cand, s_pos, w_lc);
                                n_pos  = hrbp_pkg::pos_inc(s_pos);
                                w_role = hrbp_pkg::ROLE_KEY;
                            end else begin
                                n_kind = hrbp_pkg::end_keys(s_cand, s_pos);
                                n_hdr  = hrbp_pkg::HS_SPACE;
                                w_role = hrbp_pkg::ROLE_DELIM;
                            end
                        end
                        hrbp_pkg::HS_SPACE: begin
                            if (w_byte == hrbp_pkg::CHAR_SP) begin
                                n_hdr = hrbp_pkg::HS_VAL_START;
                            end else begin
                                n_finish = hrbp_pkg::FIN_ERR;
                            end
                            w_role = hrbp_pkg::ROLE_DELIM;
                        end
                        hrbp_pkg::HS_VAL_START: begin
                            n_cand = vf_cand;
                            n_pos  = vf_pos;
                            n_len  = vf_len;
                            n_hdr  = hrbp_pkg::HS_VAL;
                            w_role = hrbp_pkg::ROLE_VALUE;
                        end
                        hrbp_pkg::HS_VAL: begin
                            if (w_byte != hrbp_pkg::CHAR_CR) begin
                                n_cand = vf_cand;
                                n_pos  = vf_pos;
                                n_len  = vf_len;
                                w_role = hrbp_pkg::ROLE_VALUE;
                            end else begin
                                if (s_kind == hrbp_pkg::KIND_LENGTH && !s_cand[1]) begin
                                    n_finish = hrbp_pkg::FIN_ERR;
                                end
                                if (s_kind == hrbp_pkg::KIND_CONN && s_cand[0] &&
                                    hrbp_pkg::word_end(hrbp_pkg::WORD_ALIVE, s_pos)) begin
                                    n_alive = 1'b1;
                                end
                                n_hdr  = hrbp_pkg::HS_LF;
                                w_role = hrbp_pkg::ROLE_DELIM;
                            end
                        end
                        hrbp_pkg::HS_LF: begin
                            if (w_byte == hrbp_pkg::CHAR_LF) begin
                                n_hdr = hrbp_pkg::HS_KEY_START;
                            end else begin
                                n_finish = hrbp_pkg::FIN_ERR;
                            end
                            w_role = hrbp_pkg::ROLE_DELIM;
                        end
                        hrbp_pkg::HS_END_LF: begin
                            if (w_byte != hrbp_pkg::CHAR_LF) begin
                                n_finish = hrbp_pkg::FIN_ERR;
                            end else if (s_method == hrbp_pkg::METH_POST && s_len != '0) begin
                                n_phase = hrbp_pkg::PH_BODY;
                                n_rem   = s_len;
                            end else begin
                                n_phase  = hrbp_pkg::PH_DONE;
                                n_finish = hrbp_pkg::FIN_DONE;
                            end
                            w_role = hrbp_pkg::ROLE_DELIM;
                        end
                        default: begin
                        end
                    endcase
                end
                hrbp_pkg::PH_BODY: begin
                    n_rem  = w_rem_dec;
                    w_role = hrbp_pkg::ROLE_BODY;
                    if (w_rem_dec == '0) begin
                        n_phase  = hrbp_pkg::PH_DONE;
                        n_finish = hrbp_pkg::FIN_DONE;
                    end
                end
                hrbp_pkg::PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hrbp_pkg::PH_LINE;
            r_line   <= hrbp_pkg::LS_METHOD_START;
            r_hdr    <= hrbp_pkg::HS_KEY_START;
            r_kind   <= hrbp_pkg::KIND_NONE;
            r_method <= hrbp_pkg::METH_NONE;
            r_finish <= hrbp_pkg::FIN_RUN;
            r_pos    <= '0;
            r_cand   <= 3'b111;
            r_alive  <= 1'b0;
            r_len    <= '0;
            r_rem    <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_line   <= n_line;
            r_hdr    <= n_hdr;
            r_kind   <= n_kind;
            r_method <= n_method;
            r_finish <= n_finish;
            r_pos    <= n_pos;
            r_cand   <= n_cand;
            r_alive  <= n_alive;
            r_len    <= n_len;
            r_rem    <= n_rem;
        end
    end

    always_comb begin
        o_result.status       = n_finish;
        o_result.byte_role    = w_role;
        o_result.method_code  = n_method;
        o_result.conn_persist = n_alive;
        o_result.body_length  = hrbp_pkg::OUT_LEN_BITS'(n_len);
        o_result.echo_byte    = w_byte;
    end

endmodule

`default_nettype wire

// ===== rtl/hrbp_out_stage.sv =====
`default_nettype none

module hrbp_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  hrbp_pkg::t_result  i_result,
    output logic               o_space,
    hrbp_out_if.source         o_res
);

    logic              r_valid;
    hrbp_pkg::t_result r_result;

    assign o_space = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.status       = r_result.status;
    assign o_res.byte_role    = r_result.byte_role;
    assign o_res.method_code  = r_result.method_code;
    assign o_res.conn_persist = r_result.conn_persist;
    assign o_res.body_length  = r_result.body_length;
    assign o_res.echo_byte    = r_result.echo_byte;

endmodule

`default_nettype wire

// ===== rtl/http_request_byte_parser_core.sv =====
// HTTP/1.1 request parser, one byte per beat.
// i_req (valid/ready) carries start_req and data_byte; start_req clears all
// parse state before its byte is parsed. o_res (valid/ready) returns one
// result beat per input beat: status, byte_role, method_code, conn_persist,
// body_length (low 32 bits, saturating) and the echoed byte.
// Path: a beat accepted into the input register has its result loaded into
// the output register, which raises o_res.valid, once the output side is free.
// Throughput: one beat per cycle while o_res.ready stays high; the parse
// step is one pass of compare and state-update logic plus a shift-add for
// the decimal length, between the input register and the result register.
// Reset: synchronous, active low; both registers empty, parse state set to
// the start of a request line.
// Stall: when o_res.ready is low a waiting result holds, the input register
// holds its beat and i_req.ready drops once that register is full; no beat
// is dropped or repeated.
`default_nettype none

module http_request_byte_parser_core #(
    parameter int unsigned LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrbp_in_if.sink     i_req,
    hrbp_out_if.source  o_res
);

    logic              w_in_valid;
    hrbp_pkg::t_beat   w_beat;
    hrbp_pkg::t_result w_result;
    logic              w_space;
    logic              w_advance;

    assign w_advance = w_in_valid && w_space;

    hrbp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_beat    (w_beat)
    );

    hrbp_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_beat    (w_beat),
        .o_result  (w_result)
    );

    hrbp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_result),
        .o_space  (w_space),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire
